// File: hdl/flf_pkg.sv
package flf_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned FactorBits = 16;
  localparam int unsigned FfWidth = 17;
  localparam int unsigned SumWidth = 64;
  localparam int unsigned WideWidth = 128;
  localparam int unsigned DivSteps = WideWidth + FracBits;
  localparam int unsigned StepWidth = $clog2(DivSteps + 1);

  localparam logic [1:0] OpAdd = 2'd0;
  localparam logic [1:0] OpEval = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic CfgForget = 1'b0;
  localparam logic CfgSmooth = 1'b1;

  typedef enum logic [4:0] {
    StIdle,
    StDecay,
    StDecayMul,
    StDen,
    StDenMul,
    StNumA,
    StNumAMul,
    StNumB,
    StNumBMul,
    StDivA,
    StDivB,
    StRatio,
    StBlend,
    StBlendMul,
    StEst,
    StEstMul,
    StOut
  } state_e;

  typedef logic signed [ValueWidth-1:0] val_t;
  typedef logic signed [SumWidth-1:0] sum_t;
  typedef logic signed [WideWidth-1:0] wide_t;

  // saturate a 128-bit signed value to the sum range [-2^62, 2^62-1]
  function automatic sum_t sat_sum(input wide_t v);
    logic signed [WideWidth-1:0] hi;
    logic signed [WideWidth-1:0] lo;
    hi = (wide_t'(1) <<< 62) - wide_t'(1);
    lo = -(wide_t'(1) <<< 62);
    if (v > hi) sat_sum = sum_t'(hi);
    else if (v < lo) sat_sum = sum_t'(lo);
    else sat_sum = v[SumWidth-1:0];
  endfunction

  function automatic val_t sat_val(input wide_t v);
    logic signed [WideWidth-1:0] hi;
    logic signed [WideWidth-1:0] lo;
    hi = (wide_t'(1) <<< (ValueWidth - 1)) - wide_t'(1);
    lo = -(wide_t'(1) <<< (ValueWidth - 1));
    if (v > hi) sat_val = val_t'(hi);
    else if (v < lo) sat_val = val_t'(lo);
    else sat_val = v[ValueWidth-1:0];
  endfunction

  // arithmetic right shift truncating toward zero
  function automatic wide_t shr_tz(input wide_t v, input int unsigned k);
    wide_t m;
    m = v[WideWidth-1] ? -v : v;
    m = m >> k;
    shr_tz = v[WideWidth-1] ? -m : m;
  endfunction

endpackage

// File: hdl/forgetting_line_fit_core.sv
// from input transfer to result valid: an add on a zero denominator skips the numerator
//   products and divisions, a clear goes straight to the result; every 64x64 product takes
//   four 32x32 partial steps on one multiplier (13 per add, 5 per evaluate), every division 144 steps
// throughput: one item at a time; s_axis_tready is low while an item is in work
// the result waits in an output register; the next item is taken once it leaves
// reset: asynchronous active low, clears all sums and line state, ff = 1.0
module forgetting_line_fit_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // x_value[31:0], y_value[63:32]
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // slope[31:0], intercept[63:32], y_estimate[95:64]
  output logic        m_axis_tuser,   // degenerate[0]
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  typedef flf_pkg::val_t val_t;
  typedef flf_pkg::sum_t sum_t;
  typedef flf_pkg::wide_t wide_t;

  flf_pkg::state_e state_q, state_d;

  logic [flf_pkg::FfWidth-1:0] ff_q;
  logic smooth_q;
  val_t x_q, y_q;
  sum_t sums_q [5];
  val_t fit_s_q, fit_i_q, pri_s_q, pri_i_q, bstart_q, bend_q, lastx_q, bl_s_q, bl_i_q;
  logic degen_q;
  logic [2:0] idx_q;
  logic [2:0] sub_q;
  wide_t acc_q, den_q, na_q, nb_q;
  val_t ratio_q;

  // shared multiplier: 33x33 signed per cycle
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  assign mp = ma * mb;

  // divider
  wide_t dn_q, dd_q;
  logic [flf_pkg::WideWidth:0] rem_q;
  logic [flf_pkg::ValueWidth:0] quo_q;
  logic over_q, dneg_q;
  logic [flf_pkg::StepWidth-1:0] step_q;
  logic [flf_pkg::WideWidth:0] rem_sh;
  logic take;
  logic [flf_pkg::ValueWidth:0] quo_nx;
  val_t div_res;
  logic [flf_pkg::ValueWidth:0] bound;

  assign bound = (flf_pkg::ValueWidth+1)'(1) << (flf_pkg::ValueWidth - 1);
  assign rem_sh = {rem_q[flf_pkg::WideWidth-1:0],
                   (step_q < flf_pkg::StepWidth'(flf_pkg::WideWidth)) ?
                   dn_q[flf_pkg::WideWidth-1] : 1'b0};
  assign take = rem_sh >= {1'b0, dd_q};
  assign quo_nx = {quo_q[flf_pkg::ValueWidth-1:0], take};

  always_comb begin
    if (dneg_q) begin
      if (over_q || quo_q >= bound) div_res = val_t'(-(wide_t'(bound)));
      else div_res = val_t'(-$signed({1'b0, quo_q}));
    end else begin
      if (over_q || quo_q >= bound) div_res = val_t'(wide_t'(bound) - wide_t'(1));
      else div_res = val_t'(quo_q);
    end
  end

  // 64x64 product by four 32x32 partials, operands a and b chosen by the sequencer
  sum_t opa, opb;
  logic [63:0] ua, ub;
  wide_t prod_u;
  logic pneg;
  assign ua = opa[63] ? 64'(-opa) : 64'(opa);
  assign ub = opb[63] ? 64'(-opb) : 64'(opb);
  always_comb begin
    case (sub_q[1:0])
      2'd0: begin ma = {1'b0, ua[31:0]};  mb = {1'b0, ub[31:0]};  end
      2'd1: begin ma = {1'b0, ua[31:0]};  mb = {1'b0, ub[63:32]}; end
      2'd2: begin ma = {1'b0, ua[63:32]}; mb = {1'b0, ub[31:0]};  end
      default: begin ma = {1'b0, ua[63:32]}; mb = {1'b0, ub[63:32]}; end
    endcase
  end
  logic [7:0] psh;
  always_comb begin
    case (sub_q[1:0])
      2'd0: psh = 8'd0;
      2'd1, 2'd2: psh = 8'd32;
      default: psh = 8'd64;
    endcase
  end
  assign pneg = opa[63] ^ opb[63];
  assign prod_u = wide_t'(mp[63:0]) << psh;

  val_t x_in, y_in;
  logic [1:0] op_in;
  assign op_in = s_axis_tuser;
  assign x_in = s_axis_tdata[31:0];
  assign y_in = s_axis_tdata[63:32];

  // operand selection
  always_comb begin
    opa = '0;
    opb = '0;
    case (state_q)
      flf_pkg::StDecayMul: begin
        if (idx_q < 3'd5) begin
          opa = sums_q[idx_q];
          opb = sum_t'(ff_q);
        end else begin
          opa = sum_t'(x_q);
          opb = (idx_q == 3'd5) ? sum_t'(x_q) : sum_t'(y_q);
        end
      end
      flf_pkg::StDenMul: begin
        opa = idx_q[0] ? sums_q[1] : sums_q[0];
        opb = idx_q[0] ? sums_q[1] : sums_q[3];
      end
      flf_pkg::StNumAMul: begin
        opa = idx_q[0] ? sums_q[1] : sums_q[0];
        opb = idx_q[0] ? sums_q[2] : sums_q[4];
      end
      flf_pkg::StNumBMul: begin
        opa = idx_q[0] ? sums_q[4] : sums_q[3];
        opb = idx_q[0] ? sums_q[1] : sums_q[2];
      end
      flf_pkg::StBlendMul: begin
        case (idx_q[1:0])
          2'd0: begin
            opa = sum_t'((33'sd1 <<< flf_pkg::FracBits) - ratio_q);
            opb = sum_t'(pri_s_q);
          end
          2'd1: begin opa = sum_t'(ratio_q); opb = sum_t'(fit_s_q); end
          2'd2: begin
            opa = sum_t'((33'sd1 <<< flf_pkg::FracBits) - ratio_q);
            opb = sum_t'(pri_i_q);
          end
          default: begin opa = sum_t'(ratio_q); opb = sum_t'(fit_i_q); end
        endcase
      end
      flf_pkg::StEstMul: begin
        opa = smooth_q ? sum_t'(bl_s_q) : sum_t'(fit_s_q);
        opb = sum_t'(x_q);
      end
      default: ;
    endcase
  end

  logic mul_last;
  assign mul_last = (sub_q[1:0] == 2'd3);
  wide_t prod_full;
  assign prod_full = pneg ? -(acc_q + prod_u) : (acc_q + prod_u);

  always_comb begin
    state_d = state_q;
    case (state_q)
      flf_pkg::StIdle:
        if (s_axis_tvalid && s_axis_tready) begin
          if (op_in == flf_pkg::OpAdd) state_d = flf_pkg::StDecayMul;
          else if (op_in == flf_pkg::OpEval) state_d = flf_pkg::StRatio;
          else if (op_in == flf_pkg::OpClear) state_d = flf_pkg::StOut;
        end
      flf_pkg::StDecayMul: if (mul_last && idx_q == 3'd6) state_d = flf_pkg::StDecay;
      flf_pkg::StDecay: state_d = flf_pkg::StDenMul;
      flf_pkg::StDenMul: if (mul_last && idx_q[0]) state_d = flf_pkg::StDen;
      flf_pkg::StDen:
        state_d = (prods_q[0] == prods_q[1]) ? flf_pkg::StOut : flf_pkg::StNumAMul;
      flf_pkg::StNumAMul: if (mul_last && idx_q[0]) state_d = flf_pkg::StNumA;
      flf_pkg::StNumA: state_d = flf_pkg::StNumBMul;
      flf_pkg::StNumBMul: if (mul_last && idx_q[0]) state_d = flf_pkg::StNumB;
      flf_pkg::StNumB: state_d = flf_pkg::StDivA;
      flf_pkg::StDivA:
        if (step_q == flf_pkg::StepWidth'(flf_pkg::DivSteps)) state_d = flf_pkg::StDivB;
      flf_pkg::StDivB:
        if (step_q == flf_pkg::StepWidth'(flf_pkg::DivSteps)) state_d = flf_pkg::StOut;
      flf_pkg::StRatio:
        if (step_q == flf_pkg::StepWidth'(flf_pkg::DivSteps)) state_d = flf_pkg::StBlendMul;
      flf_pkg::StBlendMul: if (mul_last && idx_q[1:0] == 2'd3) state_d = flf_pkg::StBlend;
      flf_pkg::StBlend: state_d = flf_pkg::StEstMul;
      flf_pkg::StEstMul: if (mul_last) state_d = flf_pkg::StEst;
      flf_pkg::StEst: state_d = flf_pkg::StOut;
      flf_pkg::StOut: if (m_axis_tready) state_d = flf_pkg::StIdle;
      default: state_d = flf_pkg::StIdle;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == flf_pkg::StIdle);
    m_axis_tvalid = (state_q == flf_pkg::StOut);
  end

  val_t yest_q;
  wide_t prods_q [2];
  logic ratio_run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= flf_pkg::StIdle;
      ff_q <= flf_pkg::FfWidth'(1 << flf_pkg::FactorBits);
      smooth_q <= 1'b0;
      for (int i = 0; i < 5; i++) sums_q[i] <= '0;
      fit_s_q <= '0; fit_i_q <= '0; pri_s_q <= '0; pri_i_q <= '0;
      bstart_q <= '0; bend_q <= '0; lastx_q <= '0; bl_s_q <= '0; bl_i_q <= '0;
      degen_q <= 1'b0;
      idx_q <= '0; sub_q <= '0; step_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == flf_pkg::CfgForget) ff_q <= cfg_data_i;
        else smooth_q <= cfg_data_i[0];
      end
      case (state_q)
        flf_pkg::StIdle:
          if (s_axis_tvalid) begin
            x_q <= x_in; y_q <= y_in;
            idx_q <= '0; sub_q <= '0; acc_q <= '0; yest_q <= '0;
            if (op_in == flf_pkg::OpClear) begin
              for (int i = 0; i < 5; i++) sums_q[i] <= '0;
              fit_s_q <= '0; fit_i_q <= '0; pri_s_q <= '0; pri_i_q <= '0;
              bstart_q <= '0; bend_q <= '0; lastx_q <= '0; bl_s_q <= '0;
              bl_i_q <= '0; degen_q <= 1'b0;
            end else if (op_in == flf_pkg::OpAdd) begin
              pri_s_q <= fit_s_q; pri_i_q <= fit_i_q;
              bend_q <= flf_pkg::sat_val(wide_t'(lastx_q) * 2 - wide_t'(bstart_q));
              bstart_q <= lastx_q;
            end else if (op_in == flf_pkg::OpEval) begin
              lastx_q <= x_in;
              step_q <= '0; rem_q <= '0; quo_q <= '0; over_q <= 1'b0; dneg_q <= 1'b0;
              if (bstart_q <= x_in && x_in <= bend_q && bend_q != bstart_q) begin
                ratio_run_q <= 1'b1;
                dn_q <= wide_t'(x_in) - wide_t'(bstart_q);
                dd_q <= wide_t'(bend_q) - wide_t'(bstart_q);
              end else begin
                ratio_run_q <= 1'b0;
                dn_q <= '0; dd_q <= wide_t'(1);
              end
            end
          end
        flf_pkg::StDecayMul, flf_pkg::StDenMul, flf_pkg::StNumAMul, flf_pkg::StNumBMul,
        flf_pkg::StBlendMul, flf_pkg::StEstMul: begin
          if (!mul_last) begin
            sub_q <= sub_q + 3'd1;
            acc_q <= acc_q + prod_u;
          end else begin
            sub_q <= '0;
            acc_q <= '0;
            if (idx_q[0] && (state_q == flf_pkg::StDenMul || state_q == flf_pkg::StNumAMul ||
                state_q == flf_pkg::StNumBMul)) idx_q <= '0;
            else idx_q <= idx_q + 3'd1;
            case (state_q)
              flf_pkg::StDecayMul: begin
                // sums 0..2 decay right after their product, sums 3 and 4 wait in prods, x*x and x*y stashed in den/na
                case (idx_q)
                  3'd0: sums_q[0] <= flf_pkg::sat_sum(
                          flf_pkg::shr_tz(prod_full, flf_pkg::FactorBits)
                          + (wide_t'(1) <<< flf_pkg::FracBits));
                  3'd1: sums_q[1] <= flf_pkg::sat_sum(
                          flf_pkg::shr_tz(prod_full, flf_pkg::FactorBits) + wide_t'(x_q));
                  3'd2: sums_q[2] <= flf_pkg::sat_sum(
                          flf_pkg::shr_tz(prod_full, flf_pkg::FactorBits) + wide_t'(y_q));
                  3'd3: prods_q[0] <= flf_pkg::shr_tz(prod_full, flf_pkg::FactorBits);
                  3'd4: prods_q[1] <= flf_pkg::shr_tz(prod_full, flf_pkg::FactorBits);
                  3'd5: den_q <= flf_pkg::shr_tz(prod_full, flf_pkg::FracBits);
                  default: na_q <= flf_pkg::shr_tz(prod_full, flf_pkg::FracBits);
                endcase
              end
              flf_pkg::StEstMul:
                yest_q <= flf_pkg::sat_val(flf_pkg::shr_tz(prod_full, flf_pkg::FracBits) +
                          wide_t'(smooth_q ? bl_i_q : fit_i_q));
              flf_pkg::StBlendMul: begin
                if (!idx_q[0]) prods_q[0] <= prod_full;
                else if (!idx_q[1])
                  bl_s_q <= flf_pkg::sat_val(flf_pkg::shr_tz(prods_q[0] + prod_full,
                                                             flf_pkg::FracBits));
                else
                  bl_i_q <= flf_pkg::sat_val(flf_pkg::shr_tz(prods_q[0] + prod_full,
                                                             flf_pkg::FracBits));
              end
              default: prods_q[idx_q[0]] <= prod_full;
            endcase
          end
        end
        flf_pkg::StDecay: begin
          sums_q[3] <= flf_pkg::sat_sum(prods_q[0] + den_q);
          sums_q[4] <= flf_pkg::sat_sum(prods_q[1] + na_q);
          idx_q <= '0;
        end
        flf_pkg::StDen: begin
          den_q <= prods_q[0] - prods_q[1];
          if (prods_q[0] == prods_q[1]) begin
            fit_s_q <= '0; fit_i_q <= '0; degen_q <= 1'b1;
          end
        end
        flf_pkg::StNumA: na_q <= prods_q[0] - prods_q[1];
        flf_pkg::StNumB: begin
          nb_q <= prods_q[0] - prods_q[1];
          dn_q <= na_q[127] ? -na_q : na_q;
          dd_q <= den_q[127] ? -den_q : den_q;
          dneg_q <= na_q[127] ^ den_q[127];
          step_q <= '0; rem_q <= '0; quo_q <= '0; over_q <= 1'b0;
        end
        flf_pkg::StDivA, flf_pkg::StDivB, flf_pkg::StRatio: begin
          if (step_q == flf_pkg::StepWidth'(flf_pkg::DivSteps)) begin
            step_q <= '0; rem_q <= '0; quo_q <= '0; over_q <= 1'b0;
            if (state_q == flf_pkg::StDivA) begin
              fit_s_q <= div_res;
              dn_q <= nb_q[127] ? -nb_q : nb_q;
              dneg_q <= nb_q[127] ^ den_q[127];
            end else if (state_q == flf_pkg::StDivB) begin
              fit_i_q <= div_res;
              degen_q <= 1'b0;
            end else begin
              ratio_q <= (!ratio_run_q || div_res > (val_t'(1) <<< flf_pkg::FracBits)) ?
                         (val_t'(1) <<< flf_pkg::FracBits) : div_res;
              idx_q <= '0;
            end
          end else begin
            step_q <= step_q + 1'b1;
            dn_q <= dn_q << 1;
            rem_q <= take ? rem_sh - {1'b0, dd_q} : rem_sh;
            if (!over_q) begin
              quo_q <= quo_nx;
              if (quo_nx > bound || quo_q[flf_pkg::ValueWidth]) over_q <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  val_t rep_s, rep_i;
  assign rep_s = smooth_q ? bl_s_q : fit_s_q;
  assign rep_i = smooth_q ? bl_i_q : fit_i_q;
  assign m_axis_tdata = {yest_q, rep_i, rep_s};
  assign m_axis_tuser = degen_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == flf_pkg::StDen && prods_q[0] == prods_q[1]) |=> degen_q)
    else $error("degenerate flag");

endmodule

// File: sim/forgetting_line_fit_core_tb.sv
module forgetting_line_fit_core_tb;

  localparam int unsigned WatchdogLimit = 20000;

  typedef struct packed {
    logic [31:0] slope;
    logic [31:0] intercept;
    logic [31:0] y_est;
    logic        degen;
  } line_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;  // x_value, y_value
  logic [1:0] s_axis_tuser = '0;   // operation
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;       // slope, intercept, y_estimate
  logic m_axis_tuser;              // degenerate
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [16:0] cfg_data_i = '0;

  forgetting_line_fit_core u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // fit state of the predictor
  logic [16:0] p_ff;
  logic        p_smooth;
  logic signed [63:0] n_w, sx, sy, sxx, sxy;
  logic signed [31:0] f_slope, f_icpt, pr_slope, pr_icpt;
  logic signed [31:0] b_start, b_end, last_x, bl_slope, bl_icpt;
  logic p_degen;

  line_result_t expected_lines[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit stall_rx_random = 1'b1;

  function automatic logic signed [127:0] tz_shift(logic signed [127:0] v, int k);
    logic signed [127:0] m;
    m = v < 0 ? -v : v;
    m = m >> k;
    return v < 0 ? -m : m;
  endfunction

  function automatic logic signed [127:0] clamp(logic signed [127:0] v,
                                                 logic signed [127:0] lim);
    if (v > lim) return lim;
    if (v < -lim - 1) return -lim - 1;
    return v;
  endfunction

  // (num << 16) / den toward zero saturated to 32 bits; 160-bit to avoid overflow
  function automatic logic signed [31:0] frac_div(logic signed [127:0] num,
                                                  logic signed [127:0] den);
    logic signed [159:0] n, d, q;
    n = 160'(num);
    d = 160'(den);
    n = n <<< 16;
    q = n / d;
    if (q > 160'sh7fffffff) return 32'h7fffffff;
    if (q < -160'sh80000000) return 32'h80000000;
    return q[31:0];
  endfunction

  function automatic logic signed [63:0] decayed(logic signed [63:0] s,
                                                 logic signed [127:0] term);
    logic signed [127:0] p;
    p = tz_shift(128'(s) * $signed({111'd0, p_ff}), 16);
    return 64'(clamp(p + term, (128'sd1 <<< 62) - 1));
  endfunction

  function automatic logic signed [31:0] mix(logic signed [31:0] prior,
                                             logic signed [31:0] fit,
                                             logic signed [63:0] r);
    logic signed [127:0] s;
    s = 128'((64'sd65536 - r)) * 128'(prior) + 128'(r) * 128'(fit);
    return 32'(clamp(tz_shift(s, 16), 128'sh7fffffff));
  endfunction

  task automatic clear_fit();
    n_w = 0; sx = 0; sy = 0; sxx = 0; sxy = 0;
    f_slope = 0; f_icpt = 0; pr_slope = 0; pr_icpt = 0;
    b_start = 0; b_end = 0; last_x = 0; bl_slope = 0; bl_icpt = 0;
    p_degen = 0;
  endtask

  task automatic predict_line(logic [1:0] op, logic signed [31:0] x,
                              logic signed [31:0] y);
    logic signed [127:0] den, na, nb, w;
    logic signed [63:0] r;
    logic signed [31:0] ls, li;
    line_result_t res;
    res.y_est = 0;
    if (op == flf_pkg::OpUnused) return;
    if (op == flf_pkg::OpClear) begin
      clear_fit();
    end else if (op == flf_pkg::OpAdd) begin
      pr_slope = f_slope;
      pr_icpt = f_icpt;
      w = 128'(last_x) * 2 - 128'(b_start);
      b_end = 32'(clamp(w, 128'sh7fffffff));
      b_start = last_x;
      n_w = decayed(n_w, 128'sd65536);
      sx = decayed(sx, 128'(x));
      sy = decayed(sy, 128'(y));
      sxx = decayed(sxx, tz_shift(128'(x) * 128'(x), 16));
      sxy = decayed(sxy, tz_shift(128'(x) * 128'(y), 16));
      den = 128'(n_w) * 128'(sxx) - 128'(sx) * 128'(sx);
      if (den == 0) begin
        f_slope = 0; f_icpt = 0; p_degen = 1;
      end else begin
        na = 128'(n_w) * 128'(sxy) - 128'(sx) * 128'(sy);
        nb = 128'(sxx) * 128'(sy) - 128'(sxy) * 128'(sx);
        f_slope = frac_div(na, den);
        f_icpt = frac_div(nb, den);
        p_degen = 0;
      end
    end else begin
      r = 65536;
      last_x = x;
      if (b_start <= x && x <= b_end && b_end != b_start)
        r = 64'(frac_div(128'(x) - 128'(b_start), 128'(b_end) - 128'(b_start)));
      if (r > 65536) r = 65536;
      bl_slope = mix(pr_slope, f_slope, r);
      bl_icpt = mix(pr_icpt, f_icpt, r);
      ls = p_smooth ? bl_slope : f_slope;
      li = p_smooth ? bl_icpt : f_icpt;
      res.y_est = 32'(clamp(tz_shift(128'(ls) * 128'(x), 16) + 128'(li), 128'sh7fffffff));
    end
    res.slope = p_smooth ? bl_slope : f_slope;
    res.intercept = p_smooth ? bl_icpt : f_icpt;
    res.degen = p_degen;
    expected_lines.push_back(res);
  endtask

  task automatic send_item(logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y);
    int n;
    n = $urandom_range(0, 8);
    if (n != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tdata <= {y, x};
    s_axis_tuser <= op;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_line(op, x, y);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [16:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == flf_pkg::CfgForget) p_ff = val;
    else p_smooth = val[0];
  endtask

  // result checker
  always @(posedge clk_i) begin
    line_result_t got, exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64], m_axis_tuser};
      if (expected_lines.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %b", m_axis_tdata, m_axis_tuser);
      end else begin
        exp_r = expected_lines.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp s=%h i=%h y=%h d=%b got s=%h i=%h y=%h d=%b",
                     exp_r.slope, exp_r.intercept, exp_r.y_est, exp_r.degen,
                     got.slope, got.intercept, got.y_est, got.degen);
        end
      end
    end
  end

  // receiver stalls: after each result, ready may drop for a random wait while stall_rx_random is set
  initial begin
    int w;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        w = stall_rx_random ? $urandom_range(0, 8) : 0;
        if (w != 0) begin
          m_axis_tready <= 1'b0;
          repeat (w) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
      end else if (!m_axis_tready) begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("forgetting_line_fit_core_tb NOT OK");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
      2: return $signed($urandom_range(0, 2000)) - 1000;
      default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  task automatic test_directed();
    send_item(flf_pkg::OpEval, 32'sd0, 32'sd0);
    send_item(flf_pkg::OpAdd, 32'sh00010000, 32'sh00020000);
    send_item(flf_pkg::OpAdd, 32'sh00010000, 32'sh00030000);  // zero denominator
    send_item(flf_pkg::OpAdd, 32'sh00020000, 32'sh00050000);
    send_item(flf_pkg::OpEval, 32'sh00030000, 32'sd0);
    send_item(flf_pkg::OpAdd, 32'sh7fffffff, 32'sh80000000);
    send_item(flf_pkg::OpAdd, 32'sh80000000, 32'sh7fffffff);
    send_item(flf_pkg::OpEval, 32'sh7fffffff, 32'sd0);
    send_item(flf_pkg::OpEval, 32'sh80000000, 32'hffffffff);
    send_item(flf_pkg::OpUnused, 32'sh12345678, 32'sh0);
    send_item(flf_pkg::OpClear, 32'hffffffff, 32'hffffffff);
    send_item(flf_pkg::OpEval, 32'sh00010000, 32'sd0);
  endtask

  task automatic test_smooth_blend();
    write_reg(flf_pkg::CfgSmooth, 17'd1);
    for (int k = 0; k < 6; k++) begin
      send_item(flf_pkg::OpEval, k << 16, 0);
      send_item(flf_pkg::OpAdd, k << 16, (3 * k + 1) << 16);
      send_item(flf_pkg::OpEval, (k << 16) + 32'h8000, 0);
      send_item(flf_pkg::OpEval, (k + 1) << 16, 0);
    end
  endtask

  task automatic test_random(int count);
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 55) send_item(flf_pkg::OpAdd, rand_val(), rand_val());
      else if (r < 93) send_item(flf_pkg::OpEval, rand_val(), rand_val());
      else if (r < 97) send_item(flf_pkg::OpClear, $urandom(), $urandom());
      else send_item(flf_pkg::OpUnused, $urandom(), $urandom());
    end
  endtask

  initial begin
    p_ff = 17'd65536;
    p_smooth = 1'b0;
    clear_fit();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_smooth_blend();
    write_reg(flf_pkg::CfgForget, 17'd0);
    test_random(60);
    write_reg(flf_pkg::CfgForget, 17'd60000);
    write_reg(flf_pkg::CfgSmooth, 17'd0);
    test_random(250);
    // sender holds back until the pipeline is empty
    drain();
    stall_rx_random = 1'b0;
    write_reg(flf_pkg::CfgForget, 17'd131071);
    test_random(60);
    stall_rx_random = 1'b1;
    write_reg(flf_pkg::CfgForget, 17'd65536);
    write_reg(flf_pkg::CfgSmooth, 17'd1);
    test_random(250);
    write_reg(flf_pkg::CfgForget, 17'd65000);
    test_random(230);
    drain();
    if (mismatches == 0 && expected_lines.size() == 0) begin
      $display("forgetting_line_fit_core_tb OK");
    end else begin
      $display("forgetting_line_fit_core_tb NOT OK");
    end
    $finish;
  end

endmodule
